/* rtl/hrr_pkg.sv */
// ----------------------------------------------------------------------------
// hrr_pkg: shared types and constants for haze radiance recovery
// Fixed-point widths, register indexes and the request and result payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package hrr_pkg;

	// transmission fraction bits (Q1.F, 1 << F stands for 1.0)
	localparam int TRANS_FRAC_BITS = 16;
	localparam int TW     = TRANS_FRAC_BITS + 1;  // transmission / floor width
	localparam int PIX_W  = 8;                    // channel width
	localparam int NCH    = 3;                    // blue, green, red
	localparam int QBITS  = PIX_W;                // quotient bits before saturation
	localparam int PROD_W = PIX_W + TW;           // atmos * divisor
	localparam int NUM_W  = PROD_W + 2;           // signed numerator
	localparam int N_W    = NUM_W + 1;            // 2*num + m
	localparam int D_W    = TW + 1;               // 2*m

	localparam logic [PIX_W-1:0] PIX_MAX     = '1;
	localparam logic [PIX_W-1:0] ATMOS_RST   = '1;
	// about 0.1 in Q1.F, rounded to nearest
	localparam logic [TW-1:0]    FLOOR_RST   = TW'(((1 << TRANS_FRAC_BITS) + 5) / 10);
	localparam logic [TW-1:0]    DIV_MIN     = TW'(1);

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATMOS_BLUE  = 2'd0,
		CFG_ATMOS_GREEN = 2'd1,
		CFG_ATMOS_RED   = 2'd2,
		CFG_TRANS_FLOOR = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] hazy_blue;
		logic [PIX_W-1:0] hazy_green;
		logic [PIX_W-1:0] hazy_red;
		logic [TW-1:0]    transmission;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] clear_blue;
		logic [PIX_W-1:0] clear_green;
		logic [PIX_W-1:0] clear_red;
	} pix_out_t;

endpackage

`default_nettype wire

/* rtl/haze_radiance_recovery.sv */
// ----------------------------------------------------------------------------
// haze_radiance_recovery: scene radiance recovery for one BGR pixel
// J = A + (I - A) / max(t, floor), rounded half away from zero, clamped.
// ----------------------------------------------------------------------------
// Stages: divisor select, numerator, overflow check, 8 divider steps and the
// output register.
// Throughput: one pixel per cycle while the output is not stalled; the quotient
// comes from an 8-stage restoring divider, one quotient bit per pipeline stage.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset: valid bits clear, atmos registers to 255, floor to about 0.1.
`default_nettype none

module haze_radiance_recovery import hrr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [TW-1:0]         cfg_wdata,
	input  wire logic                  pixel_valid,
	output logic                       pixel_ready,
	input  wire pix_in_t               pixel,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output pix_out_t                   result
);

	// configuration registers
	logic [PIX_W-1:0] atmos_q [NCH];
	logic [TW-1:0]    floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) atmos_q[c] <= ATMOS_RST;
			floor_q <= FLOOR_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ATMOS_BLUE:  atmos_q[0] <= cfg_wdata[PIX_W-1:0];
				CFG_ATMOS_GREEN: atmos_q[1] <= cfg_wdata[PIX_W-1:0];
				CFG_ATMOS_RED:   atmos_q[2] <= cfg_wdata[PIX_W-1:0];
				CFG_TRANS_FLOOR: floor_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// whole pipeline moves when the output register is free or drained
	logic adv;
	logic out_valid_q;
	assign adv         = !out_valid_q || result_ready;
	assign pixel_ready = adv;

	// ---- stage 1: divisor select ----
	logic             vld_s1;
	logic [PIX_W-1:0] pix_s1 [NCH];
	logic [TW-1:0]    m_s1;
	logic [TW-1:0]    m_nxt;

	always_comb begin
		m_nxt = (pixel.transmission > floor_q) ? pixel.transmission : floor_q;
		if (m_nxt == '0) m_nxt = DIV_MIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= pixel_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1[0] <= pixel.hazy_blue;
			pix_s1[1] <= pixel.hazy_green;
			pix_s1[2] <= pixel.hazy_red;
			m_s1      <= m_nxt;
		end
	end

	// ---- stage 2: numerator num = A*m + (I - A) << F, then 2*num + m ----
	logic             vld_s2;
	logic [N_W-1:0]   n_s2   [NCH];
	logic             neg_s2 [NCH];
	logic [D_W-1:0]   d_s2;
	logic [PROD_W-1:0]       prod [NCH];
	logic signed [PIX_W:0]   diff [NCH];
	logic signed [NUM_W-1:0] num  [NCH];

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			prod[c] = PROD_W'(atmos_q[c]) * PROD_W'(m_s1);
			diff[c] = $signed({1'b0, pix_s1[c]}) - $signed({1'b0, atmos_q[c]});
			num[c]  = $signed(NUM_W'(prod[c]))
				+ ($signed(NUM_W'(diff[c])) <<< TRANS_FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < NCH; c++) begin
				n_s2[c]   <= (N_W'(unsigned'(num[c])) << 1) + N_W'(m_s1);
				neg_s2[c] <= num[c][NUM_W-1];
			end
			d_s2 <= {m_s1, 1'b0};
		end
	end

	// ---- stage 3 and divider steps ----
	// index 0 is stage 3 (overflow check); index k>0 resolves quotient bit QBITS-k
	logic [QBITS:0]   vld_sd;
	logic [N_W-1:0]   rem_sd [QBITS+1][NCH];
	logic [QBITS-1:0] q_sd   [QBITS+1][NCH];
	logic             neg_sd [QBITS+1][NCH];
	logic             ovf_sd [QBITS+1][NCH];
	logic [D_W-1:0]   d_sd   [QBITS+1];

	// divider step next values
	logic [N_W-1:0]   shd   [QBITS+1];
	logic             ge    [QBITS+1][NCH];
	logic [N_W-1:0]   rem_n [QBITS+1][NCH];
	logic [QBITS-1:0] q_n   [QBITS+1][NCH];
	logic [N_W-1:0]   lim;

	always_comb begin
		lim = N_W'(d_s2) << QBITS;
		shd[0] = '0;
		for (int c = 0; c < NCH; c++) begin
			ge[0][c]    = 1'b0;
			rem_n[0][c] = '0;
			q_n[0][c]   = '0;
		end
		for (int k = 1; k <= QBITS; k++) begin
			shd[k] = N_W'(d_sd[k-1]) << (QBITS - k);
			for (int c = 0; c < NCH; c++) begin
				ge[k][c]    = rem_sd[k-1][c] >= shd[k];
				rem_n[k][c] = ge[k][c] ? (rem_sd[k-1][c] - shd[k]) : rem_sd[k-1][c];
				q_n[k][c]   = q_sd[k-1][c];
				q_n[k][c][QBITS-k] = ge[k][c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sd <= '0;
		else if (adv) vld_sd <= {vld_sd[QBITS-1:0], vld_s2};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 3: quotient of 256 or more saturates
			d_sd[0] <= d_s2;
			for (int c = 0; c < NCH; c++) begin
				rem_sd[0][c] <= n_s2[c];
				q_sd[0][c]   <= '0;
				neg_sd[0][c] <= neg_s2[c];
				ovf_sd[0][c] <= n_s2[c] >= lim;
			end
			for (int k = 1; k <= QBITS; k++) begin
				d_sd[k] <= d_sd[k-1];
				for (int c = 0; c < NCH; c++) begin
					rem_sd[k][c] <= rem_n[k][c];
					q_sd[k][c]   <= q_n[k][c];
					neg_sd[k][c] <= neg_sd[k-1][c];
					ovf_sd[k][c] <= ovf_sd[k-1][c];
				end
			end
		end
	end

	// ---- output register: clamp ----
	logic [PIX_W-1:0] clr [NCH];

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			if (neg_sd[QBITS][c])      clr[c] = '0;
			else if (ovf_sd[QBITS][c]) clr[c] = PIX_MAX;
			else                       clr[c] = q_sd[QBITS][c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= vld_sd[QBITS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.clear_blue  <= clr[0];
			result.clear_green <= clr[1];
			result.clear_red   <= clr[2];
		end
	end

	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

/* bench/haze_radiance_recovery_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haze_radiance_recovery_tb: self-checking bench for radiance recovery
// Drives BGR pixels with transmission values through the block under several
// atmospheric light and floor settings. A local predictor computes each
// recovered pixel, and every result is compared field by field in order.
// ----------------------------------------------------------------------------

module haze_radiance_recovery_tb;
	import hrr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_CYCLES = 24;
	localparam int IDLE_PCT      = 19;
	localparam int PHASE_ITEMS   = 61;
	localparam int TRANS_MAX     = (1 << TW) - 1;
	localparam int UNITY         = 1 << TRANS_FRAC_BITS;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TW-1:0]    cfg_wdata = '0;
	logic             pixel_valid = 1'b0;
	logic             pixel_ready;
	pix_in_t          pixel = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	pix_out_t         result;

	// local copy of the register file
	logic [PIX_W-1:0] light_blue  = ATMOS_RST;
	logic [PIX_W-1:0] light_green = ATMOS_RST;
	logic [PIX_W-1:0] light_red   = ATMOS_RST;
	logic [TW-1:0]    t_floor     = FLOOR_RST;

	pix_out_t pending_clear[$];
	pix_out_t want_pixel;
	int       mismatch_count = 0;
	int       cycle_count = 0;
	bit       no_idle = 1'b0;

	haze_radiance_recovery dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #1 clk = ~clk;

	// one recovered channel: A + (I - A) / div, rounded half away from zero
	function automatic logic [PIX_W-1:0] radiance_level(input logic [PIX_W-1:0] level,
			input logic [PIX_W-1:0] light, input logic [TW-1:0] div);
		longint diff, m, num, q;
		diff = longint'(level) - longint'(light);
		m    = longint'(div);
		num  = longint'(light) * m + diff * (longint'(1) << TRANS_FRAC_BITS);
		if (num >= 0) begin
			q = (2 * num + m) / (2 * m);
		end else begin
			q = -((2 * (-num) + m) / (2 * m));
		end
		if (q < 0)
			q = 0;
		if (q > 255)
			q = 255;
		return q[PIX_W-1:0];
	endfunction

	function automatic pix_out_t clear_pixel(input pix_in_t p);
		pix_out_t o;
		logic [TW-1:0] div;
		div = (p.transmission > t_floor) ? p.transmission : t_floor;
		// both zero: fall back to the smallest step
		if (div == '0)
			div = DIV_MIN;
		o.clear_blue  = radiance_level(p.hazy_blue,  light_blue,  div);
		o.clear_green = radiance_level(p.hazy_green, light_green, div);
		o.clear_red   = radiance_level(p.hazy_red,   light_red,   div);
		return o;
	endfunction

	function automatic pix_in_t make_pixel(input int b, input int g, input int r, input int t);
		pix_in_t p;
		p.hazy_blue    = b[PIX_W-1:0];
		p.hazy_green   = g[PIX_W-1:0];
		p.hazy_red     = r[PIX_W-1:0];
		p.transmission = t[TW-1:0];
		return p;
	endfunction

	// cycle watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: check accepted results, stall at random
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_clear.size() == 0) begin
				$error("result with no request outstanding: %h", result);
				mismatch_count++;
			end else begin
				want_pixel = pending_clear.pop_front();
				if (result.clear_blue !== want_pixel.clear_blue) begin
					$error("clear_blue: expected %0d, actual %0d",
						want_pixel.clear_blue, result.clear_blue);
					mismatch_count++;
				end
				if (result.clear_green !== want_pixel.clear_green) begin
					$error("clear_green: expected %0d, actual %0d",
						want_pixel.clear_green, result.clear_green);
					mismatch_count++;
				end
				if (result.clear_red !== want_pixel.clear_red) begin
					$error("clear_red: expected %0d, actual %0d",
						want_pixel.clear_red, result.clear_red);
					mismatch_count++;
				end
			end
		end
		result_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	// send one pixel request; valid stays high when no gap is taken
	task automatic send_pixel(input pix_in_t p);
		int gap;
		gap = 0;
		while (!no_idle && $urandom_range(99) < IDLE_PCT)
			gap++;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel       <= p;
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (!pixel_ready)
			@(posedge clk);
		pending_clear.push_back(clear_pixel(p));
	endtask

	// stop sending, wait for all results, then let the pipeline settle
	task automatic drain_pipeline();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending_clear.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all four registers; upper data bits of the 8-bit ones are dropped
	task automatic program_atmosphere(input int wb, input int wg,
			input int wr, input int wf);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_ATMOS_BLUE;
		cfg_wdata <= wb[TW-1:0];
		@(posedge clk);
		cfg_index <= CFG_ATMOS_GREEN;
		cfg_wdata <= wg[TW-1:0];
		@(posedge clk);
		cfg_index <= CFG_ATMOS_RED;
		cfg_wdata <= wr[TW-1:0];
		@(posedge clk);
		cfg_index <= CFG_TRANS_FLOOR;
		cfg_wdata <= wf[TW-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		light_blue  = wb[PIX_W-1:0];
		light_green = wg[PIX_W-1:0];
		light_red   = wr[PIX_W-1:0];
		t_floor     = wf[TW-1:0];
	endtask

	// reset settings: pixel and transmission extremes
	task automatic test_reset_defaults();
		send_pixel(make_pixel(0, 0, 0, 0));
		send_pixel(make_pixel(255, 255, 255, UNITY));
		send_pixel(make_pixel(0, 128, 255, TRANS_MAX));
		send_pixel(make_pixel(255, 0, 17, int'(FLOOR_RST)));
		send_pixel(make_pixel(200, 100, 50, int'(FLOOR_RST) + 1));
		send_pixel(make_pixel(170, 85, 255, UNITY - 1));
		drain_pipeline();
	endtask

	// zero floor with zero transmission divides by the smallest step
	task automatic test_zero_divisor();
		program_atmosphere(128, 0, 255, 0);
		send_pixel(make_pixel(128, 0, 255, 0));
		send_pixel(make_pixel(127, 1, 254, 0));
		send_pixel(make_pixel(129, 255, 0, 0));
		send_pixel(make_pixel(0, 1, 255, 1));
		send_pixel(make_pixel(255, 0, 128, 2));
		drain_pipeline();
	endtask

	// floor and transmission above 1.0 shrink the correction
	task automatic test_above_unity();
		program_atmosphere(0, 255, 100, TRANS_MAX);
		send_pixel(make_pixel(255, 0, 0, 0));
		send_pixel(make_pixel(255, 0, 255, TRANS_MAX));
		send_pixel(make_pixel(1, 254, 99, UNITY + 1));
		drain_pipeline();
		program_atmosphere(50, 200, 0, UNITY + 1);
		send_pixel(make_pixel(51, 199, 255, 100000));
		send_pixel(make_pixel(0, 255, 3, UNITY));
		drain_pipeline();
	endtask

	// fractional divisors: rounding of both signs and saturation at both ends
	task automatic test_rounding_saturation();
		program_atmosphere(128, 64, 200, 43691);
		send_pixel(make_pixel(129, 63, 201, 43691));
		send_pixel(make_pixel(127, 65, 199, 21845));
		send_pixel(make_pixel(255, 0, 255, 1));
		send_pixel(make_pixel(0, 255, 0, 1));
		send_pixel(make_pixel(130, 62, 190, 52429));
		drain_pipeline();
	endtask

	// random pixels over a range of register settings
	task automatic test_random_pixels();
		int phase, k, t, fl;
		int b, g, r;
		for (phase = 0; phase < 9; phase++) begin
			case (phase)
				0: fl = 1;
				1: fl = UNITY;
				2: fl = 0;
				3: fl = TRANS_MAX;
				4: fl = $urandom_range(TRANS_MAX);
				default: fl = $urandom_range(UNITY, 1);
			endcase
			if (phase == 0) begin
				program_atmosphere(0, 0, 0, fl);
			end else if (phase == 1) begin
				program_atmosphere(TRANS_MAX, TRANS_MAX, TRANS_MAX, fl);
			end else begin
				program_atmosphere($urandom_range(TRANS_MAX), $urandom_range(TRANS_MAX),
					$urandom_range(TRANS_MAX), fl);
			end
			// one phase runs with both sides always willing
			no_idle = (phase == 4);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				case ($urandom_range(3))
					0: t = $urandom_range(TRANS_MAX);
					1: t = $urandom_range(UNITY);
					2: begin
						t = fl + $urandom_range(64) - 32;
						if (t < 0)
							t = 0;
						if (t > TRANS_MAX)
							t = TRANS_MAX;
					end
					default: t = $urandom_range(8192);
				endcase
				b = ($urandom_range(7) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
				g = ($urandom_range(7) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
				r = ($urandom_range(7) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
				send_pixel(make_pixel(b, g, r, t));
			end
			drain_pipeline();
			no_idle = 1'b0;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_zero_divisor();
		test_above_unity();
		test_rounding_saturation();
		test_random_pixels();
		drain_pipeline();
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/hrr_pkg.sv
rtl/haze_radiance_recovery.sv
bench/haze_radiance_recovery_tb.sv
